### hw/rtl/qmi_pkg.sv
// Package: command codes, sizes and shared types for the queue machine interpreter.
`timescale 1ns / 1ps
`default_nettype none
package qmi_pkg;
  localparam int QUEUE_DEPTH = 4096;
  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int REG_COUNT = 26;
  localparam int WORD_W = 16;

  typedef enum logic [4:0] {
    CMD_PUSH = 5'd0, CMD_ADD = 5'd1, CMD_SUB = 5'd2, CMD_MUL = 5'd3,
    CMD_DIV = 5'd4, CMD_MOD = 5'd5, CMD_STORE = 5'd6, CMD_LOAD = 5'd7,
    CMD_PRINTQ = 5'd8, CMD_PRINTR = 5'd9, CMD_CHARQ = 5'd10,
    CMD_CHARR = 5'd11, CMD_LABEL = 5'd12, CMD_JMP = 5'd13, CMD_JZ = 5'd14,
    CMD_JEQ = 5'd15, CMD_JGT = 5'd16, CMD_QUIT = 5'd17
  } cmd_t;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_NUM = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;
  localparam logic [1:0] KIND_HALT = 2'd3;
  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_UNDER = 2'd1;
  localparam logic [1:0] FAULT_OVER = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_POPA, ST_POPB, ST_CALC, ST_DIVW, ST_PUSH, ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;
endpackage
`default_nettype wire

### hw/rtl/qmi_divider.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qmi_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire qmi_pkg::div_req_t req,
  output qmi_pkg::div_rsp_t      rsp
);
  import qmi_pkg::*;
  localparam int CNT_W = $clog2(WORD_W + 1);
  logic busy;
  logic done;
  logic [CNT_W-1:0] cnt;
  logic [WORD_W-1:0] quo, rem, dsr;
  logic [WORD_W:0] trial;

  assign trial = {rem, quo[WORD_W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(WORD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      if (!trial[WORD_W]) begin
        rem <= trial[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= {rem[WORD_W-2:0], quo[WORD_W-1]};
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
  assign rsp.remainder = rem;

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done) else $error("divider done held");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !req.start) else $error("divider restarted while busy");
  a_done_end: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> !busy) else $error("done while busy");
endmodule
`default_nettype wire

### hw/rtl/queue_machine_interpreter.sv
// Top level: queue machine instruction executor with queue memory and register file.
// Flow: push/load/label/jump/print-reg/quit go from accept straight to DONE; store/print-queue/char-queue
//   pop once first; add/sub/mul pop twice, then compute and push; div/mod wait on a 16-step divider.
// One word in flight; the next word is accepted no earlier than the edge that takes the result.
// Reset: queue empty, registers zero; queue memory content is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module queue_machine_interpreter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  cmd,
  input  wire logic [4:0]  first_reg,
  input  wire logic [4:0]  second_reg,
  input  wire logic [15:0] immediate,
  input  wire logic [15:0] branch_target,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             jump_taken,
  output logic [15:0]      jump_target,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_value,
  output logic [1:0]       fault
);
  import qmi_pkg::*;

  logic [WORD_W-1:0] qmem [QUEUE_DEPTH];
  logic [WORD_W-1:0] qrd;
  logic [QA_W-1:0] head, tail;
  logic [QC_W-1:0] count;
  logic [WORD_W-1:0] regs [REG_COUNT];

  state_t state, state_next;
  logic [4:0] c_cmd, c_r1;
  logic [WORD_W-1:0] a, b, res;
  logic [WORD_W-1:0] r1v, r2v;
  div_req_t dreq;
  div_rsp_t drsp;

  logic q_wr, q_pop;
  logic [WORD_W-1:0] q_wdata;

  logic in_fire;
  logic acc_taken;
  logic [1:0] acc_kind;
  logic [WORD_W-1:0] acc_value;
  logic [1:0] acc_fault;

  qmi_divider u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign r1v = (first_reg < 5'(REG_COUNT)) ? regs[first_reg] : '0;
  assign r2v = (second_reg < 5'(REG_COUNT)) ? regs[second_reg] : '0;
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (q_wr) qmem[tail] <= q_wdata;
    qrd <= qmem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) begin
        unique case (cmd)
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_STORE, CMD_PRINTQ,
          CMD_CHARQ: state_next = ST_POPA;
          default: state_next = ST_DONE;
        endcase
      end
      ST_POPA: state_next = (c_cmd inside {CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV,
                             CMD_MOD}) ? ST_POPB : ST_DONE;
      ST_POPB: state_next = ST_CALC;
      ST_CALC: state_next = (c_cmd == CMD_DIV || c_cmd == CMD_MOD) ? ST_DIVW : ST_PUSH;
      ST_DIVW: if (drsp.done) state_next = ST_PUSH;
      ST_PUSH: state_next = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Pops happen in POPA/POPB; for POPA the read of head is already registered because
  // head does not move in IDLE; POPB reads through the bypass below instead.
  logic pop_ok;
  assign pop_ok = (count != '0);

  always_comb begin
    q_wr = 1'b0;
    q_wdata = res;
    if (in_fire && count < QC_W'(QUEUE_DEPTH)) begin
      if (cmd == CMD_PUSH) begin q_wr = 1'b1; q_wdata = immediate; end
      else if (cmd == CMD_LOAD) begin q_wr = 1'b1; q_wdata = r1v; end
    end else if (state == ST_PUSH && count < QC_W'(QUEUE_DEPTH)) begin
      q_wr = 1'b1;
    end
  end

  always_comb begin
    q_pop = ((state == ST_POPA) || (state == ST_POPB)) && pop_ok;
  end

  always_comb begin
    acc_taken = 1'b0;
    acc_kind = KIND_NONE;
    acc_value = '0;
    acc_fault = FAULT_NONE;
    unique case (cmd)
      CMD_PUSH, CMD_LOAD:
        if (count >= QC_W'(QUEUE_DEPTH)) acc_fault = FAULT_OVER;
      CMD_PRINTR: begin acc_kind = KIND_NUM; acc_value = r1v; end
      CMD_CHARR: begin acc_kind = KIND_CHAR; acc_value = {8'd0, r1v[7:0]}; end
      CMD_JMP: acc_taken = 1'b1;
      CMD_JZ: acc_taken = (r1v == '0);
      CMD_JEQ: acc_taken = (r1v == r2v);
      CMD_JGT: acc_taken = (r1v > r2v);
      CMD_QUIT: acc_kind = KIND_HALT;
      default: ;
    endcase
  end

  assign dreq.start = (state == ST_CALC) && (c_cmd == CMD_DIV || c_cmd == CMD_MOD);
  assign dreq.dividend = a;
  assign dreq.divisor = b;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      count <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs[i] <= '0;
    end else begin
      if (q_wr) tail <= (tail == QA_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
      if (q_pop) head <= (head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
      count <= count + QC_W'(q_wr) - QC_W'(q_pop);
      if (state == ST_POPA && c_cmd == CMD_STORE && c_r1 < 5'(REG_COUNT))
        regs[c_r1] <= pop_ok ? qrd : '0;
      if (state == ST_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // After a pop the queue read data reflects the new head only once the head register and then the
  // read register have updated; POPB is entered right after POPA so the registered read must be bypassed.
  logic [WORD_W-1:0] qmem_nxt;
  always_ff @(posedge clk) begin
    if (q_pop) qmem_nxt <= qmem[(head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1];
  end

  logic [WORD_W-1:0] prod;
  assign prod = a * b;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      c_cmd <= cmd;
      c_r1 <= first_reg;
      jump_taken <= acc_taken;
      jump_target <= acc_taken ? branch_target : '0;
      out_kind <= acc_kind;
      out_value <= acc_value;
      fault <= acc_fault;
    end
    case (state)
      ST_POPA: begin
        a <= pop_ok ? qrd : '0;
        if (!pop_ok) fault <= FAULT_UNDER;
        if (c_cmd == CMD_PRINTQ) begin
          out_kind <= KIND_NUM; out_value <= pop_ok ? qrd : '0;
        end
        if (c_cmd == CMD_CHARQ) begin
          out_kind <= KIND_CHAR; out_value <= pop_ok ? {8'd0, qrd[7:0]} : '0;
        end
      end
      ST_POPB: begin
        b <= pop_ok ? ((head == tail && count == QC_W'(1)) ? qrd : qmem_nxt) : '0;
        if (!pop_ok) fault <= FAULT_UNDER;
      end
      ST_CALC: begin
        if (c_cmd == CMD_ADD) res <= a + b;
        else if (c_cmd == CMD_SUB) res <= a - b;
        else res <= prod;
      end
      ST_DIVW: if (drsp.done) begin
        if (b == '0) res <= '0;
        else res <= (c_cmd == CMD_DIV) ? drsp.quotient : drsp.remainder;
      end
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QUEUE_DEPTH)) else $error("queue count beyond depth");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail)) else $error("empty queue with pointer gap");
  a_busy_no_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result lost");
  a_no_pop_push: assert property (@(posedge clk) disable iff (rst)
    !(q_wr && q_pop)) else $error("push and pop in one cycle");
endmodule
`default_nettype wire
